FILE: hdl/smce_pkg.sv
`default_nettype none

package smce_pkg;

	// sequencer states, one-hot
	typedef enum logic [23:0] {
		ST_IDLE    = 24'h000001,
		ST_E_RD    = 24'h000002,
		ST_E_T     = 24'h000004,
		ST_E_K     = 24'h000008,
		ST_E_MUL   = 24'h000010,
		ST_E_DL    = 24'h000020,
		ST_E_TERM  = 24'h000040,
		ST_E_WR    = 24'h000080,
		ST_N_RD    = 24'h000100,
		ST_N_LD    = 24'h000200,
		ST_N_RES   = 24'h000400,
		ST_OUT     = 24'h000800,
		ST_L_NORM  = 24'h001000,
		ST_L_Z     = 24'h002000,
		ST_L_ZSQ   = 24'h004000,
		ST_L_ZSET  = 24'h008000,
		ST_L_SD    = 24'h010000,
		ST_L_ACC   = 24'h020000,
		ST_L_PW    = 24'h040000,
		ST_L_MM    = 24'h080000,
		ST_L_FIN   = 24'h100000,
		ST_ROW_FIN = 24'h200000,
		ST_MEAN    = 24'h400000,
		ST_DIV     = 24'h800000
	} state_t;

	localparam logic [31:0] LN2_Q24     = 32'd11629080;
	localparam logic [31:0] LN2_Q30     = 32'd744261118;
	// 31 * ln2 in Q.24: at or above it exp underflows to zero
	localparam logic [31:0] EXP_K_LIMIT = 32'd360501480;
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [23:0] ONE_Q22     = 24'h40_0000;
	localparam logic [23:0] EPS_Q22     = 24'd4;
	localparam logic [3:0]  EXP_TERMS   = 4'd10;
	localparam logic [3:0]  LOG_TERMS   = 4'd10;
	localparam logic [4:0]  LOG_TOP     = 5'd22;
	localparam logic [39:0] LOSS_MAX    = 40'hFF_FFFF_FFFF;
	localparam logic [23:0] MEAN_MAX    = 24'hFF_FFFF;

endpackage

`default_nettype wire

FILE: hdl/smce_ram.sv
`default_nettype none

module smce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/softmax_cross_entropy_loss_unit.sv
// channel  dir  tdata (low bit up)                         tlast      tuser
// s_*      in   logit[15:0] label[19:16] zero pad         row_end    batch_end
// m_*      out  gradient[23:0] class_index[27:24]          final_res  loss_valid
//               mean_loss[51:28] zero pad
//
// A score that does not close a row is taken while the sequencer stays in idle.
// Closing a row runs exp per class (10 series terms, each a 31-bit quotient from
// the shared divider), then normalizing per class (45-bit quotient), then the log
// term and, at batch end, the batch mean (40-bit quotient).
// All division runs on one radix-2 restoring divider, one quotient bit per cycle.
// s_tready is low from row end until row loss is summed, or batch loss taken.
// arst_n clears the sequencer, the row and the batch totals at once.
`default_nettype none

module softmax_cross_entropy_loss_unit #(
	parameter int MAX_CLASSES = 16,
	parameter int MAX_ROWS    = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // logit[15:0], label[19:16], zero pad
	input  wire logic        s_tlast,
	input  wire logic        s_tuser,  // batch_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [55:0] m_tdata,  // gradient, class_index, mean_loss, zero pad
	output logic             m_tlast,
	output logic             m_tuser   // loss_valid
);

	import smce_pkg::*;

	localparam int IW  = $clog2(MAX_CLASSES);
	localparam int CW  = $clog2(MAX_CLASSES + 1);
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int ETW = 23 + $clog2(MAX_CLASSES);

	state_t state_q, ret_q;

	logic [CW-1:0]        cnt_q, i_q;
	logic signed [15:0]   peak_q;
	logic [3:0]           label_q;
	logic                 batch_q;
	logic [ETW-1:0]       tot_q;
	logic [39:0]          loss_q;
	logic [RW-1:0]        rows_q;
	logic [31:0]          kr_q;
	logic [4:0]           k_q;
	logic [2:0]           bitc_q;
	logic [29:0]          r30_q;
	logic [30:0]          term_q;
	logic signed [31:0]   sum_q;
	logic [3:0]           tn_q;
	logic [63:0]          prod_q;
	logic [63:0]          num_q, quo_q;
	logic [31:0]          den_q, rem_q;
	logic [6:0]           dcnt_q;
	logic [23:0]          qlab_q;
	logic [22:0]          qs_q;
	logic [4:0]           m_q;
	logic [29:0]          z_q, z2_q, pw_q;
	logic [33:0]          acc_q;
	logic [3:0]           sn_q;
	logic [21:0]          row_loss_q;
	logic                 out_valid_q, out_last_q, out_lv_q;
	logic [23:0]          out_grad_q, out_mean_q;
	logic [3:0]           out_cls_q;

	// ports of the two buffers
	logic                 sc_we;
	logic signed [15:0]   sc_rdata;
	logic                 ex_we;
	logic [23:0]          ex_wdata, ex_rdata;

	smce_ram #(.WIDTH(16), .DEPTH(MAX_CLASSES)) u_score_ram (
		.clk   (clk),
		.we    (sc_we),
		.waddr (cnt_q[IW-1:0]),
		.wdata (s_tdata[15:0]),
		.raddr (i_q[IW-1:0]),
		.rdata (sc_rdata)
	);

	smce_ram #(.WIDTH(24), .DEPTH(MAX_CLASSES)) u_exp_ram (
		.clk   (clk),
		.we    (ex_we),
		.waddr (i_q[IW-1:0]),
		.wdata (ex_wdata),
		.raddr (i_q[IW-1:0]),
		.rdata (ex_rdata)
	);

	logic in_acc, out_acc, room;
	logic last_i, lab_hit, lab_in_row;
	logic [CW+3:0] i_ext;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = out_valid_q && m_tready;
	assign room     = (cnt_q < CW'(MAX_CLASSES));
	assign sc_we    = in_acc && room;
	assign ex_we    = (state_q == ST_E_WR);

	assign i_ext      = {4'b0, i_q};
	assign last_i     = (i_q == CW'(cnt_q - 1'b1));
	assign lab_hit    = ({{CW{1'b0}}, label_q} == i_ext);
	assign lab_in_row = ({{CW{1'b0}}, label_q} < {4'b0, cnt_q});

	// exp helpers
	logic [16:0] t_diff;
	logic [31:0] big, ln2_sh;
	logic        k_ge;
	logic [31:0] kr_next;
	logic [30:0] s_pos;
	logic [5:0]  e_sh;
	logic [39:0] e_round;

	assign t_diff  = {peak_q[15], peak_q} - {sc_rdata[15], sc_rdata};
	assign big     = {t_diff[15:0], 16'b0};
	assign ln2_sh  = LN2_Q24 << bitc_q;
	assign k_ge    = (kr_q >= ln2_sh);
	assign kr_next = k_ge ? kr_q - ln2_sh : kr_q;
	assign s_pos   = sum_q[31] ? 31'd0 : sum_q[30:0];
	assign e_sh    = 6'd8 + {1'b0, k_q};
	assign e_round = ({9'b0, s_pos} + (40'd1 << (e_sh - 6'd1))) >> e_sh;
	assign ex_wdata = e_round[23:0];

	// normalize and loss helpers
	logic [44:0] n_num;
	logic [23:0] q_val;
	logic [29:0] f30;
	logic signed [40:0] l_res;
	logic [40:0] l_rnd;
	logic [40:0] l_sum;
	logic [39:0] loss_new;
	logic [RW-1:0] rows_new;

	assign n_num    = {ex_rdata[22:0], 22'b0} + 45'(tot_q >> 1);
	assign q_val    = {1'b0, quo_q[22:0]} + EPS_Q22;
	assign f30      = {qs_q[21:0], 8'b0};
	assign l_res    = $signed({5'b0, prod_q[35:0]}) - $signed({6'b0, acc_q, 1'b0});
	assign l_rnd    = 41'(l_res) + 41'd8192;
	assign l_sum    = {1'b0, loss_q} + 41'(row_loss_q);
	assign loss_new = l_sum[40] ? LOSS_MAX : l_sum[39:0];
	assign rows_new = (rows_q < RW'(MAX_ROWS)) ? rows_q + 1'b1 : rows_q;

	// shared multiplier operands
	logic        mul_en;
	logic [31:0] mul_a, mul_b;

	always_comb begin
		mul_en = 1'b1;
		mul_a  = 32'd0;
		mul_b  = 32'd0;
		case (state_q)
			ST_E_MUL: begin
				mul_a = {1'b0, term_q};
				mul_b = {2'b0, r30_q};
			end
			ST_L_ZSQ: begin
				mul_a = {2'b0, z_q};
				mul_b = {2'b0, z_q};
			end
			ST_L_ACC: begin
				mul_a = {2'b0, pw_q};
				mul_b = {2'b0, z2_q};
			end
			ST_L_MM: begin
				mul_a = {27'b0, LOG_TOP - m_q};
				mul_b = LN2_Q30;
			end
			default: mul_en = 1'b0;
		endcase
	end

	// shared divider load
	logic        dl_en;
	logic [63:0] dl_num;
	logic [31:0] dl_den;
	logic [6:0]  dl_nb;
	state_t      dl_ret;

	always_comb begin
		dl_en  = 1'b0;
		dl_num = 64'd0;
		dl_den = 32'd1;
		dl_nb  = 7'd0;
		dl_ret = ST_IDLE;
		case (state_q)
			ST_E_DL: begin
				dl_en  = 1'b1;
				dl_num = {prod_q[60:30], 33'b0};
				dl_den = {28'b0, tn_q};
				dl_nb  = 7'd31;
				dl_ret = ST_E_TERM;
			end
			ST_N_LD: begin
				dl_en  = (tot_q != '0);
				dl_num = {n_num, 19'b0};
				dl_den = 32'(tot_q);
				dl_nb  = 7'd45;
				dl_ret = ST_N_RES;
			end
			ST_L_NORM: begin
				dl_en  = qs_q[22];
				dl_num = {f30, 34'b0};
				dl_den = {2'b10, f30};
				dl_nb  = 7'd60;
				dl_ret = ST_L_Z;
			end
			ST_L_SD: begin
				dl_en  = 1'b1;
				dl_num = {pw_q, 34'b0};
				dl_den = {27'b0, sn_q, 1'b1};
				dl_nb  = 7'd30;
				dl_ret = ST_L_ACC;
			end
			ST_ROW_FIN: begin
				dl_en  = batch_q;
				dl_num = {loss_new, 24'b0};
				dl_den = 32'(rows_new);
				dl_nb  = 7'd40;
				dl_ret = ST_MEAN;
			end
			default: dl_en = 1'b0;
		endcase
	end

	// one restoring step
	logic [32:0] d_sh;
	logic        d_ge;
	logic [32:0] d_sub;

	assign d_sh  = {rem_q, num_q[63]};
	assign d_ge  = (d_sh >= {1'b0, den_q});
	assign d_sub = d_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			cnt_q       <= '0;
			i_q         <= '0;
			peak_q      <= -16'sd32768;
			label_q     <= '0;
			batch_q     <= 1'b0;
			tot_q       <= '0;
			loss_q      <= '0;
			rows_q      <= '0;
			kr_q        <= '0;
			k_q         <= '0;
			bitc_q      <= '0;
			r30_q       <= '0;
			term_q      <= '0;
			sum_q       <= '0;
			tn_q        <= '0;
			prod_q      <= '0;
			num_q       <= '0;
			quo_q       <= '0;
			den_q       <= '0;
			rem_q       <= '0;
			dcnt_q      <= '0;
			qlab_q      <= '0;
			qs_q        <= '0;
			m_q         <= '0;
			z_q         <= '0;
			z2_q        <= '0;
			pw_q        <= '0;
			acc_q       <= '0;
			sn_q        <= '0;
			row_loss_q  <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_lv_q    <= 1'b0;
			out_grad_q  <= '0;
			out_mean_q  <= '0;
			out_cls_q   <= '0;
		end else begin
			if (mul_en) begin
				prod_q <= mul_a * mul_b;
			end
			if (dl_en) begin
				num_q   <= dl_num;
				den_q   <= dl_den;
				rem_q   <= '0;
				quo_q   <= '0;
				dcnt_q  <= dl_nb;
				ret_q   <= dl_ret;
				state_q <= ST_DIV;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (room) begin
							cnt_q <= cnt_q + 1'b1;
							if ($signed(s_tdata[15:0]) > peak_q) begin
								peak_q <= $signed(s_tdata[15:0]);
							end
						end
						if (s_tlast) begin
							label_q <= s_tdata[19:16];
							batch_q <= s_tuser;
							tot_q   <= '0;
							i_q     <= '0;
							state_q <= ST_E_RD;
						end
					end
				end
				ST_E_RD: state_q <= ST_E_T;
				ST_E_T: begin
					if (big >= EXP_K_LIMIT) begin
						// underflow: force the result to zero
						sum_q   <= '0;
						k_q     <= '0;
						state_q <= ST_E_WR;
					end else begin
						kr_q    <= big;
						k_q     <= '0;
						bitc_q  <= 3'd4;
						state_q <= ST_E_K;
					end
				end
				ST_E_K: begin
					kr_q          <= kr_next;
					k_q[bitc_q]   <= k_ge;
					bitc_q        <= bitc_q - 1'b1;
					if (bitc_q == 3'd0) begin
						r30_q   <= {kr_next[23:0], 6'b0};
						term_q  <= ONE_Q30;
						sum_q   <= $signed({1'b0, ONE_Q30});
						tn_q    <= 4'd1;
						state_q <= ST_E_MUL;
					end
				end
				ST_E_MUL: state_q <= ST_E_DL;
				// divider load and the jump to ST_DIV happen above
				ST_E_DL, ST_L_SD: begin
				end
				ST_E_TERM: begin
					term_q <= quo_q[30:0];
					if (tn_q[0]) begin
						sum_q <= sum_q - $signed({1'b0, quo_q[30:0]});
					end else begin
						sum_q <= sum_q + $signed({1'b0, quo_q[30:0]});
					end
					if (tn_q == EXP_TERMS) begin
						state_q <= ST_E_WR;
					end else begin
						tn_q    <= tn_q + 1'b1;
						state_q <= ST_E_MUL;
					end
				end
				ST_E_WR: begin
					tot_q <= tot_q + ETW'(ex_wdata);
					if (last_i) begin
						i_q <= '0;
					end else begin
						i_q <= i_q + 1'b1;
					end
					state_q <= last_i ? ST_N_RD : ST_E_RD;
				end
				ST_N_RD: state_q <= ST_N_LD;
				ST_N_LD: begin
					if (tot_q == '0) begin
						quo_q   <= '0;
						state_q <= ST_N_RES;
					end
				end
				ST_N_RES: begin
					out_grad_q  <= lab_hit ? q_val - ONE_Q22 : q_val;
					out_cls_q   <= i_ext[3:0];
					out_mean_q  <= '0;
					out_lv_q    <= 1'b0;
					out_last_q  <= last_i && !batch_q;
					out_valid_q <= 1'b1;
					if (lab_hit) begin
						qlab_q <= q_val;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (out_lv_q) begin
							state_q <= ST_IDLE;
						end else if (last_i) begin
							if (lab_in_row) begin
								qs_q    <= qlab_q[22:0];
								m_q     <= LOG_TOP;
								state_q <= ST_L_NORM;
							end else begin
								row_loss_q <= '0;
								state_q    <= ST_ROW_FIN;
							end
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_N_RD;
						end
					end
				end
				ST_L_NORM: begin
					// bring the leading one up to bit 22
					if (!qs_q[22]) begin
						qs_q <= {qs_q[21:0], 1'b0};
						m_q  <= m_q - 1'b1;
					end
				end
				ST_L_Z: begin
					z_q     <= quo_q[29:0];
					state_q <= ST_L_ZSQ;
				end
				ST_L_ZSQ: state_q <= ST_L_ZSET;
				ST_L_ZSET: begin
					z2_q    <= prod_q[59:30];
					pw_q    <= z_q;
					acc_q   <= '0;
					sn_q    <= '0;
					state_q <= ST_L_SD;
				end
				ST_L_ACC: begin
					acc_q <= acc_q + 34'(quo_q[29:0]);
					if (sn_q == LOG_TERMS - 1'b1) begin
						state_q <= ST_L_MM;
					end else begin
						state_q <= ST_L_PW;
					end
				end
				ST_L_PW: begin
					pw_q    <= prod_q[59:30];
					sn_q    <= sn_q + 1'b1;
					state_q <= ST_L_SD;
				end
				ST_L_MM: state_q <= ST_L_FIN;
				ST_L_FIN: begin
					if (l_res <= 0) begin
						row_loss_q <= '0;
					end else begin
						row_loss_q <= l_rnd[35:14];
					end
					state_q <= ST_ROW_FIN;
				end
				ST_ROW_FIN: begin
					loss_q <= loss_new;
					rows_q <= rows_new;
					peak_q <= -16'sd32768;
					cnt_q  <= '0;
					if (!batch_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MEAN: begin
					out_grad_q  <= '0;
					out_cls_q   <= '0;
					out_mean_q  <= (quo_q[39:24] != '0) ? MEAN_MAX : quo_q[23:0];
					out_lv_q    <= 1'b1;
					out_last_q  <= 1'b1;
					out_valid_q <= 1'b1;
					loss_q      <= '0;
					rows_q      <= '0;
					state_q     <= ST_OUT;
				end
				ST_DIV: begin
					if (dcnt_q != '0) begin
						rem_q  <= d_ge ? d_sub[31:0] : d_sh[31:0];
						quo_q  <= {quo_q[62:0], d_ge};
						num_q  <= {num_q[62:0], 1'b0};
						dcnt_q <= dcnt_q - 1'b1;
					end else begin
						state_q <= ret_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_mean_q, out_cls_q, out_grad_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_lv_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result is pending");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_CLASSES))
		else $error("class count beyond buffer depth");

	a_rows_range: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q <= RW'(MAX_ROWS))
		else $error("row count beyond saturation");

	a_loss_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("batch loss request not marked last");

	a_loss_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser |=> s_tready)
		else $error("not ready after batch loss request");

endmodule

`default_nettype wire
